[rtl/signed_subset_sum_search_top_assert.svh]
// assertion macros for the signed subset-sum search block
`ifndef SIGNED_SUBSET_SUM_SEARCH_TOP_ASSERT_SVH
`define SIGNED_SUBSET_SUM_SEARCH_TOP_ASSERT_SVH

// same-cycle implication under reset
`define SSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sss_pkg.sv]
// shared constants and types of the signed subset-sum search block
package sss_pkg;

    localparam int MAX_W = 16;
    localparam int IDX_W = $clog2(MAX_W);
    localparam int CNT_W = $clog2(MAX_W + 1);
    localparam int WGT_W = 16;
    localparam int SUM_W = 21;
    localparam int PRE_W = 20;
    localparam int GAP_W = PRE_W + 2;

    typedef logic signed [1:0]       t_sign;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [WGT_W-1:0]        t_weight;

    localparam t_sign SIGN_MINUS = -2'sd1;
    localparam t_sign SIGN_ZERO  = 2'sd0;
    localparam t_sign SIGN_PLUS  = 2'sd1;

    // controller to datapath
    typedef struct packed {
        logic load;       // store incoming weight
        logic start;      // clear sum and depth, search begins
        logic descend;    // pick minus at current depth, go one deeper
        logic advance;    // next sign at parent level, add its weight
        logic ascend;     // undo plus at parent level, go one up
        logic use_prev;   // read store at depth minus one
        logic emit_init;  // rewind depth to walk the answer
        logic emit_hit;   // register one answer word
        logic emit_miss;  // register the not-found word
        logic finish;     // clear set for the next load
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_last;
        logic depth_eq_n;
        logic depth_zero;
        logic sum_hit;
        logic prune;
        logic choice_plus;
        logic emit_last;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/sss_dp.sv]
// datapath: weight store, prefix sums, sign choices, running sum and output register
module sss_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sss_pkg::t_ctrl_cmd            i_cmd,
    input  logic                          i_cfg_wen,
    input  logic [sss_pkg::SUM_W-1:0]     i_cfg_wdata,
    input  sss_pkg::t_weight              i_weight,
    input  logic                          i_out_stall,
    output sss_pkg::t_dp_status           o_status,
    output logic                          o_out_valid,
    output logic                          o_found,
    output logic [sss_pkg::IDX_W-1:0]     o_position,
    output sss_pkg::t_sign                o_sign,
    output sss_pkg::t_weight              o_weight_out,
    output logic                          o_last_result
);

    // storage
    sss_pkg::t_weight              r_weight [sss_pkg::MAX_W];
    logic [sss_pkg::PRE_W-1:0]     r_prefix [sss_pkg::MAX_W];
    sss_pkg::t_sign                r_choice [sss_pkg::MAX_W];

    // control registers
    sss_pkg::t_sum                 r_target;
    sss_pkg::t_sum                 r_sum, n_sum;
    logic [sss_pkg::CNT_W-1:0]     r_count;
    logic [sss_pkg::CNT_W-1:0]     r_depth, n_depth;
    logic [sss_pkg::PRE_W-1:0]     r_total;
    logic                          r_out_valid;

    // output payload
    logic                          r_found;
    logic [sss_pkg::IDX_W-1:0]     r_position;
    sss_pkg::t_sign                r_sign;
    sss_pkg::t_weight              r_weight_out;
    logic                          r_last_result;

    logic [sss_pkg::IDX_W-1:0]     rd_addr;
    sss_pkg::t_weight              rd_weight;
    sss_pkg::t_sign                rd_choice;
    logic [sss_pkg::PRE_W-1:0]     rd_prefix;
    sss_pkg::t_sum                 w_ext;
    logic [sss_pkg::PRE_W-1:0]     suffix;
    logic signed [sss_pkg::GAP_W-1:0] gap, suffix_s;
    logic                          out_free;

    // store read port, parent level while backtracking
    always_comb begin
        if (i_cmd.use_prev) begin
            rd_addr = sss_pkg::IDX_W'(r_depth - 1'b1);
        end else begin
            rd_addr = r_depth[sss_pkg::IDX_W-1:0];
        end
    end

    assign rd_weight = r_weight[rd_addr];
    assign rd_choice = r_choice[rd_addr];
    assign rd_prefix = r_prefix[r_depth[sss_pkg::IDX_W-1:0]];
    assign w_ext     = sss_pkg::t_sum'({{(sss_pkg::SUM_W - sss_pkg::WGT_W){1'b0}}, rd_weight});

    // reach test: target minus sum against what the remaining weights can give
    assign suffix   = r_total - rd_prefix;
    assign suffix_s = $signed({2'b00, suffix});
    assign gap      = sss_pkg::GAP_W'(r_target) - sss_pkg::GAP_W'(r_sum);

    assign out_free = !r_out_valid || !i_out_stall;

    // status back to the controller
    always_comb begin
        o_status.count_last  = (r_count == sss_pkg::CNT_W'(sss_pkg::MAX_W - 1));
        o_status.depth_eq_n  = (r_depth == r_count);
        o_status.depth_zero  = (r_depth == '0);
        o_status.sum_hit     = (r_sum == r_target);
        o_status.prune       = (gap > suffix_s) || (gap < -suffix_s);
        o_status.choice_plus = (rd_choice == sss_pkg::SIGN_PLUS);
        o_status.emit_last   = (r_depth == r_count - 1'b1);
        o_status.out_free    = out_free;
    end

    // running sum and depth
    always_comb begin
        n_sum   = r_sum;
        n_depth = r_depth;
        if (i_cmd.start || i_cmd.finish) begin
            n_sum   = '0;
            n_depth = '0;
        end else if (i_cmd.descend) begin
            n_sum   = r_sum - w_ext;
            n_depth = r_depth + 1'b1;
        end else if (i_cmd.advance) begin
            n_sum   = r_sum + w_ext;
        end else if (i_cmd.ascend) begin
            n_sum   = r_sum - w_ext;
            n_depth = r_depth - 1'b1;
        end else if (i_cmd.emit_init) begin
            n_depth = '0;
        end else if (i_cmd.emit_hit) begin
            n_depth = r_depth + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_sum       <= '0;
            r_depth     <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_target <= i_cfg_wdata;
            end
            r_sum   <= n_sum;
            r_depth <= n_depth;
            if (i_cmd.finish) begin
                r_count <= '0;
                r_total <= '0;
            end else if (i_cmd.load) begin
                r_count <= r_count + 1'b1;
                r_total <= r_total + sss_pkg::PRE_W'(i_weight);
            end
            if (i_cmd.emit_hit || i_cmd.emit_miss) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // weight store, prefix sums and sign choices
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_weight[r_count[sss_pkg::IDX_W-1:0]] <= i_weight;
            r_prefix[r_count[sss_pkg::IDX_W-1:0]] <= r_total;
        end
        if (i_cmd.descend) begin
            r_choice[rd_addr] <= sss_pkg::SIGN_MINUS;
        end else if (i_cmd.advance) begin
            r_choice[rd_addr] <= rd_choice + sss_pkg::SIGN_PLUS;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_hit) begin
            r_found       <= 1'b1;
            r_position    <= rd_addr;
            r_sign        <= rd_choice;
            r_weight_out  <= rd_weight;
            r_last_result <= o_status.emit_last;
        end else if (i_cmd.emit_miss) begin
            r_found       <= 1'b0;
            r_position    <= '0;
            r_sign        <= sss_pkg::SIGN_ZERO;
            r_weight_out  <= '0;
            r_last_result <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_position    = r_position;
    assign o_sign        = r_sign;
    assign o_weight_out  = r_weight_out;
    assign o_last_result = r_last_result;

endmodule

[rtl/sss_ctrl.sv]
// controller: load, depth-first search and answer sequencing
module sss_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_is_last,
    input  sss_pkg::t_dp_status   i_status,
    output sss_pkg::t_ctrl_cmd    o_cmd,
    output logic                  o_in_stall
);

    localparam logic [2:0] ST_LOAD      = 3'd0;
    localparam logic [2:0] ST_ENTER     = 3'd1;
    localparam logic [2:0] ST_RETURN    = 3'd2;
    localparam logic [2:0] ST_EMIT_HIT  = 3'd3;
    localparam logic [2:0] ST_EMIT_MISS = 3'd4;

    logic [2:0] r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_is_last || i_status.count_last) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_ENTER;
                    end
                end
            end
            ST_ENTER: begin
                if (i_status.depth_eq_n) begin
                    if (i_status.sum_hit) begin
                        o_cmd.emit_init = 1'b1;
                        n_state         = ST_EMIT_HIT;
                    end else begin
                        n_state = ST_RETURN;
                    end
                end else if (i_status.prune) begin
                    n_state = ST_RETURN;
                end else begin
                    o_cmd.descend = 1'b1;
                end
            end
            ST_RETURN: begin
                o_cmd.use_prev = 1'b1;
                if (i_status.depth_zero) begin
                    n_state = ST_EMIT_MISS;
                end else if (i_status.choice_plus) begin
                    o_cmd.ascend = 1'b1;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = ST_ENTER;
                end
            end
            ST_EMIT_HIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_hit = 1'b1;
                    if (i_status.emit_last) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_LOAD;
                    end
                end
            end
            ST_EMIT_MISS: begin
                if (i_status.out_free) begin
                    o_cmd.emit_miss = 1'b1;
                    o_cmd.finish    = 1'b1;
                    n_state         = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_LOAD);

endmodule

[rtl/signed_subset_sum_search_top.sv]
// top level of the signed subset-sum search block
//
// Input channel (i_in_valid / o_in_stall) carries one weight per word, with
// i_is_last marking the final weight of a set; a set of 16 ends by itself.
// Loading takes one word per cycle. After the last word the input stalls
// while a depth-first search over signs minus, zero, plus runs, one search
// step per cycle through the single running-sum adder; the search is cut
// short where the remaining weights cannot reach the target.
// Output channel (o_out_valid / i_out_stall) then gives N words, one per
// cycle, position 0 first, the last flagged by o_last_result; or one
// not-found word with o_found low. Each word sits in an output register, so
// the next set can load while the final word still waits. A stall on the
// output holds the word and pauses the answer sequence.
// i_cfg_wen / i_cfg_wdata write the signed target; write it only while idle.
// Reset (i_rst_n low, synchronous) clears the target to zero, empties the
// set and drops output valid; stored weights are not cleared.
`include "signed_subset_sum_search_top_assert.svh"

module signed_subset_sum_search_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [sss_pkg::SUM_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sss_pkg::WGT_W-1:0]     i_weight,
    input  logic                          i_is_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [3:0]                    o_position,
    output logic signed [1:0]             o_sign,
    output logic [sss_pkg::WGT_W-1:0]     o_weight_out,
    output logic                          o_last_result
);

    sss_pkg::t_ctrl_cmd  cmd;
    sss_pkg::t_dp_status status;

    // sequencing
    sss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_is_last  (i_is_last),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // storage and arithmetic
    sss_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_weight      (i_weight),
        .i_out_stall   (i_out_stall),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_sign        (o_sign),
        .o_weight_out  (o_weight_out),
        .o_last_result (o_last_result)
    );

    // checks
    `SSS_ASSERT_NOW(a_miss_is_last, o_out_valid && !o_found, o_last_result && o_weight_out == '0, "not-found word must be a lone last word")
    `SSS_ASSERT_NOW(a_no_overwrite, cmd.emit_hit || cmd.emit_miss, status.out_free, "answer word written over a pending word")
    `SSS_ASSERT_NOW(a_descend_legal, cmd.descend, !status.prune && !status.depth_eq_n && o_in_stall, "descent past the set or into a dead branch")
    `SSS_ASSERT_NEXT(a_load_sets_valid, cmd.emit_hit || cmd.emit_miss, o_out_valid, "answer word not presented")

endmodule
